FILE: design/sagc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sagc_pkg
// Shared types, constants and the speed table of the speech AGC gain tracker.
// ----------------------------------------------------------------------------
package sagc_pkg;

    localparam int LEVEL_W = 32;
    localparam int GAIN_W  = 24;
    localparam int CNT_W   = 7;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = 48;
    localparam int QUO_W   = 24;
    localparam int QB_W    = 5;

    localparam int SETTLE_PERIOD_DEF = 64;
    localparam int SETTLE_TIME_DEF   = 48;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN    = 24'd1048576;
    localparam logic [GAIN_W-1:0]  GAIN_MAX      = 24'hFFFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 32'hFFFFFFFF;
    localparam logic [LEVEL_W-1:0] SF_MIN        = 32'd128;
    localparam logic [LEVEL_W-1:0] NOISE_MIN     = 32'd32768;
    localparam logic [LEVEL_W-1:0] NOISE_MAXDIFF = 32'd1048576;
    localparam logic [LEVEL_W-1:0] NOISE_MAXSTEP = 32'd2048;
    localparam logic [LEVEL_W-1:0] MIN_SLOW      = 32'd10125312;
    localparam logic [31:0]        LA_Q15        = 32'd5793;
    localparam logic [31:0]        LF_Q15        = 32'd24374;
    localparam logic [DEN_W-1:0]   OFFSET_Q45    = 48'd247175367885;
    localparam logic [NUM_W-1:0]   NUMER_Q65     = 64'd2073457268441376358;

    localparam logic [QB_W-1:0] QB_SPEED = 5'd4;
    localparam logic [QB_W-1:0] QB_GAIN  = 5'd24;

    // configuration register indexes
    localparam logic CFG_AGC_ENABLE  = 1'b0;
    localparam logic CFG_STEREO_MODE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FP,
        ST_LVL,
        ST_CLS,
        ST_KDIV,
        ST_SLOW,
        ST_D1,
        ST_D2,
        ST_DEN,
        ST_GDIV,
        ST_GATE,
        ST_GTMUL,
        ST_GTDIV,
        ST_GFIN,
        ST_GOUT,
        ST_GRES
    } sagc_state_t;

    typedef struct packed {
        logic            start;
        logic [QB_W-1:0] qbits;
    } sagc_div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sagc_div_sts_t;

    // speed table, Q0.16
    function automatic logic [13:0] speed_q16(input logic [3:0] k);
        logic [13:0] v;
        case (k)
            4'd0:    v = 14'd14510;
            4'd1:    v = 14'd8408;
            4'd2:    v = 14'd5734;
            4'd3:    v = 14'd4024;
            4'd4:    v = 14'd2779;
            4'd5:    v = 14'd1796;
            4'd6:    v = 14'd990;
            4'd7:    v = 14'd308;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/speech_agc_gain_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// speech_agc_gain_tracker_core
// Speech AGC: per-frame level tracking and stage gain update.
// ----------------------------------------------------------------------------
// One beat on the slave side carries a frame's channel levels and incoming
// gain; one beat on the master side returns the new gain, the stage gain and
// a skip flag. A small sequencer drives one shared 32 x 32 multiplier and one
// restoring divider that yields one quotient bit per cycle. A frame with zero
// power skips the divisions; a full frame runs the gain division and, where
// needed, the speed lookup and noise gate divisions. The input is taken only
// while the sequencer is idle and no result waits in the pending slot; a
// finished result passes from the pending slot to the output register, and a
// new frame is accepted while it waits there.
module speech_agc_gain_tracker_core
    import sagc_pkg::*;
#(
    parameter int SETTLE_PERIOD = SETTLE_PERIOD_DEF,
    parameter int SETTLE_TIME   = SETTLE_TIME_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // level_first [31:0], level_second [63:32], gain_in [87:64]
    input  wire logic [87:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // gain_out [23:0], stage_gain [47:24]
    output logic      [47:0] m_tdata,
    // frame_skipped [0]
    output logic             m_tuser
);

    localparam logic [CNT_W-1:0] PERIOD_C = CNT_W'(SETTLE_PERIOD);
    localparam logic [CNT_W-1:0] TIME_C   = CNT_W'(SETTLE_TIME);

    sagc_state_t state_reg, state_next;

    logic agc_enable_reg, stereo_mode_reg;

    // tracker state
    logic [LEVEL_W-1:0] fast_reg, slow_reg, noise_reg;
    logic [CNT_W-1:0]   settle_reg;
    logic [GAIN_W-1:0]  cg_reg;

    // frame working registers
    logic [LEVEL_W-1:0] lvl_reg, fp_reg;
    logic [GAIN_W-1:0]  gin_reg, gn_reg;
    logic [DEN_W-1:0]   d1_reg;
    logic               up_reg;

    // output register
    logic               out_valid_reg;
    logic [GAIN_W-1:0]  out_gout_reg, out_stage_reg;
    logic               out_skip_reg;
    logic               pend_valid_reg;
    logic [GAIN_W-1:0]  pend_gout_reg;
    logic               pend_skip_reg;

    // shared units
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod;
    sagc_div_ctl_t      div_ctl;
    sagc_div_sts_t      div_sts;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [QUO_W-1:0]   quo;

    // combinational datapath
    logic [32:0]        lvl_sum;
    logic [LEVEL_W-1:0] fp;
    logic [LEVEL_W-1:0] fast_new, noise_new, fast_diff, noise_diff;
    logic [32:0]        noise_step;
    logic               cls_quiet, cls_speech;
    logic [3:0]         k;
    logic [13:0]        sp;
    logic [LEVEL_W-1:0] delta;
    logic [32:0]        slow_up;
    logic [LEVEL_W-1:0] slow_dn, slow_new;
    logic [DEN_W-1:0]   d2;
    logic [33:0]        four_n;
    logic [LEVEL_W-1:0] gate_diff;
    logic [GAIN_W-1:0]  gout;

    sagc_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    sagc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (div_num),
        .den   (div_den),
        .sts   (div_sts),
        .quo   (quo)
    );

    // frame power: saturate to 32 bits after dropping 20 fraction bits
    assign lvl_sum = {1'b0, s_tdata[31:0]} + {1'b0, s_tdata[63:32]};
    assign fp      = (|prod[63:52]) ? LEVEL_MAX : prod[51:20];

    // fast level: instant attack, 1/32 decay, floor
    always_comb
    begin
        fast_diff = fast_reg - fp;
        if (fp > fast_reg)
            fast_new = fp;
        else
            fast_new = fast_reg - (fast_diff >> 5);
        if (fast_new < SF_MIN)
            fast_new = SF_MIN;
    end

    // noise floor: kick start, instant release, limited attack
    always_comb
    begin
        noise_diff = fp - noise_reg;
        noise_step = {1'b0, noise_reg} + {1'b0, NOISE_MAXSTEP};
        if (noise_reg <= NOISE_MIN)
            noise_new = fp;
        else
        begin
            if (fp < noise_reg)
                noise_new = fp;
            else if (noise_diff < NOISE_MAXDIFF)
                noise_new = noise_reg + (noise_diff >> 9);
            else
                noise_new = noise_step[32] ? LEVEL_MAX : noise_step[31:0];
            if (noise_new < NOISE_MIN)
                noise_new = NOISE_MIN;
        end
    end

    assign cls_quiet  = {3'b000, fast_reg} < {noise_reg, 3'b000};
    assign cls_speech = {4'b0000, fp_reg} > {noise_reg, 4'b0000};

    // speed lookup: clamp ratio at 8, quarter speed outside the settle window
    always_comb
    begin
        k  = (quo[3:0] > 4'd8) ? 4'd8 : quo[3:0];
        sp = speed_q16(k);
        if (up_reg)
        begin
            if (settle_reg == '0)
                sp = sp >> 2;
        end
        else if ((settle_reg == '0) || (settle_reg > TIME_C))
            sp = sp >> 2;
    end

    // slow level step
    always_comb
    begin
        delta   = prod[47:16];
        slow_up = {1'b0, slow_reg} + {1'b0, delta};
        slow_dn = slow_reg - delta;
        if (up_reg)
        begin
            slow_new = slow_up[32] ? LEVEL_MAX : slow_up[31:0];
            if (slow_new > fast_reg)
                slow_new = fast_reg;
        end
        else
        begin
            slow_new = slow_dn;
            if (slow_new < MIN_SLOW)
                slow_new = MIN_SLOW;
            if (slow_new < fast_reg)
                slow_new = fast_reg;
        end
    end

    assign d2        = prod[DEN_W-1:0] + OFFSET_Q45;
    assign four_n    = {noise_reg, 2'b00};
    assign gate_diff = fast_reg - four_n[31:0];
    assign gout      = (|prod[63:44]) ? GAIN_MAX : prod[43:20];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid && s_tready)
                    state_next = ST_FP;
            ST_FP:
                state_next = ST_LVL;
            ST_LVL:
                state_next = (fp == '0) ? ST_IDLE : ST_CLS;
            ST_CLS:
                if (cls_quiet || !cls_speech)
                    state_next = ST_D1;
                else
                    state_next = ST_KDIV;
            ST_KDIV:
                if (div_sts.done)
                    state_next = ST_SLOW;
            ST_SLOW:
                state_next = ST_D1;
            ST_D1:
                state_next = ST_D2;
            ST_D2:
                state_next = ST_DEN;
            ST_DEN:
                state_next = ST_GDIV;
            ST_GDIV:
                if (div_sts.done)
                    state_next = ST_GATE;
            ST_GATE:
                if ((gn_reg > UNITY_GAIN) && (four_n < {2'b00, fast_reg}))
                    state_next = ST_GTMUL;
                else
                    state_next = ST_GFIN;
            ST_GTMUL:
                state_next = ST_GTDIV;
            ST_GTDIV:
                if (div_sts.done)
                    state_next = ST_GFIN;
            ST_GFIN:
                state_next = ST_GOUT;
            ST_GOUT:
                state_next = ST_GRES;
            ST_GRES:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // unit control and operand selection
    always_comb
    begin
        mul_a         = lvl_reg;
        mul_b         = {8'd0, gin_reg};
        div_ctl.start = 1'b0;
        div_ctl.qbits = QB_GAIN;
        div_num       = NUMER_Q65;
        div_den       = (d1_reg > d2) ? d1_reg : d2;
        // idle only once any earlier result has left the pending slot
        s_tready      = (state_reg == ST_IDLE) && !pend_valid_reg;
        case (state_reg)
            ST_CLS:
            begin
                div_ctl.start = !cls_quiet && cls_speech;
                div_ctl.qbits = QB_SPEED;
                if (fast_reg > slow_reg)
                begin
                    div_num = {29'd0, slow_reg, 3'b000};
                    div_den = {16'd0, fast_reg};
                end
                else
                begin
                    div_num = {29'd0, fast_reg, 3'b000};
                    div_den = {16'd0, slow_reg};
                end
            end
            ST_KDIV:
            begin
                mul_a = slow_reg;
                mul_b = {18'd0, sp};
            end
            ST_D1:
            begin
                mul_a = fast_reg;
                mul_b = LA_Q15;
            end
            ST_D2:
            begin
                mul_a = slow_reg;
                mul_b = LF_Q15;
            end
            ST_DEN:
                div_ctl.start = 1'b1;
            ST_GATE:
            begin
                mul_a = {8'd0, gn_reg};
                mul_b = gate_diff;
            end
            ST_GTMUL:
            begin
                div_ctl.start = 1'b1;
                div_num       = prod;
                div_den       = {16'd0, fast_reg};
            end
            ST_GOUT:
            begin
                mul_a = {8'd0, gin_reg};
                mul_b = {8'd0, cg_reg};
            end
            default:
            begin
                mul_a = lvl_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agc_enable_reg  <= 1'b1;
            stereo_mode_reg <= 1'b0;
            fast_reg        <= '0;
            slow_reg        <= MIN_SLOW;
            noise_reg       <= '0;
            settle_reg      <= '0;
            cg_reg          <= UNITY_GAIN;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_AGC_ENABLE:  agc_enable_reg  <= cfg_wdata;
                    CFG_STEREO_MODE: stereo_mode_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_LVL:
                    if (fp != '0)
                    begin
                        fast_reg  <= fast_new;
                        noise_reg <= noise_new;
                    end
                ST_CLS:
                    // restart the settle window on a quiet frame
                    if (cls_quiet)
                        settle_reg <= PERIOD_C;
                ST_SLOW:
                begin
                    slow_reg <= slow_new;
                    if (settle_reg != '0)
                        settle_reg <= settle_reg - 7'd1;
                end
                ST_GFIN:
                    cg_reg <= agc_enable_reg ? gn_reg : UNITY_GAIN;
                default: ;
            endcase
        end
    end

    // frame working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (s_tvalid && s_tready)
                begin
                    lvl_reg <= stereo_mode_reg ? lvl_sum[32:1] : s_tdata[31:0];
                    gin_reg <= s_tdata[87:64];
                end
            ST_LVL:
                fp_reg <= fp;
            ST_CLS:
                up_reg <= fast_reg > slow_reg;
            ST_D2:
                // the limiter runs at four times the fast level while settling
                d1_reg <= (settle_reg != '0) ? {1'b0, prod[44:0], 2'b00}
                                             : {3'b000, prod[44:0]};
            ST_GDIV:
                if (div_sts.done)
                    gn_reg <= quo;
            ST_GATE:
                // gate wiped out the gain: hold unity
                if ((gn_reg > UNITY_GAIN) && (four_n >= {2'b00, fast_reg}))
                    gn_reg <= UNITY_GAIN;
            ST_GTDIV:
                if (div_sts.done)
                    gn_reg <= (quo < UNITY_GAIN) ? UNITY_GAIN : quo;
            default: ;
        endcase
    end

    // result hand-off: a pending slot feeds the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_LVL) && (fp == '0))
                pend_valid_reg <= 1'b1;
            else if (state_reg == ST_GRES)
                pend_valid_reg <= 1'b1;
            else if (pend_valid_reg && (!out_valid_reg || m_tready))
                pend_valid_reg <= 1'b0;

            if (pend_valid_reg && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_LVL) && (fp == '0))
        begin
            pend_gout_reg <= gin_reg;
            pend_skip_reg <= 1'b1;
        end
        else if (state_reg == ST_GRES)
        begin
            pend_gout_reg <= gout;
            pend_skip_reg <= 1'b0;
        end
        if (pend_valid_reg && (!out_valid_reg || m_tready))
        begin
            out_gout_reg  <= pend_gout_reg;
            out_stage_reg <= cg_reg;
            out_skip_reg  <= pend_skip_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_stage_reg, out_gout_reg};
    assign m_tuser  = out_skip_reg;

    // the divider is never restarted mid-division
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_sts.busy)
        else $error("divider started while busy");

    // a quotient arrives only where the sequencer waits for one
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == ST_KDIV || state_reg == ST_GDIV ||
                          state_reg == ST_GTDIV))
        else $error("divider result not expected");

    // settle counter never exceeds the settle period
    a_settle_range: assert property (@(posedge clk) disable iff (!rst_n)
        settle_reg <= PERIOD_C)
        else $error("settle counter out of range");

    // no new frame is taken while a result still waits in the pending slot
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !s_tready)
        else $error("frame accepted with result pending");

endmodule
`default_nettype wire

FILE: design/sagc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sagc_mul
// Shared 32 x 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module sagc_mul
    import sagc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic      [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'd0, op_a} * {32'd0, op_b};
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: design/sagc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sagc_div
// Restoring divider, one quotient bit a cycle, saturating on overflow.
// ----------------------------------------------------------------------------
module sagc_div
    import sagc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sagc_div_ctl_t    ctl,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output sagc_div_sts_t         sts,
    output logic      [QUO_W-1:0] quo
);

    localparam int W = DEN_W + QUO_W;

    logic             run_reg;
    logic             done_reg;
    logic [QB_W-1:0]  idx_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [W-1:0]     lim;
    logic [W-1:0]     trial;
    logic [W-1:0]     rem_ext;
    logic [W-1:0]     num_ext;

    assign lim     = {{QUO_W{1'b0}}, den} << ctl.qbits;
    assign trial   = {{QUO_W{1'b0}}, den_reg} << idx_reg;
    assign rem_ext = {{(W-NUM_W){1'b0}}, rem_reg};
    assign num_ext = {{(W-NUM_W){1'b0}}, num};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                if (num_ext >= lim)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                    idx_reg <= ctl.qbits - 5'd1;
                end
            end
            else if (run_reg)
            begin
                idx_reg <= idx_reg - 5'd1;
                if (idx_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= num;
            den_reg <= den;
            // overflow saturates the quotient
            quo_reg <= (num_ext >= lim) ? '1 : '0;
        end
        else if (run_reg && (rem_ext >= trial))
        begin
            rem_reg          <= rem_reg - trial[NUM_W-1:0];
            quo_reg[idx_reg] <= 1'b1;
        end
    end

    assign sts.busy = run_reg;
    assign sts.done = done_reg;
    assign quo      = quo_reg;

endmodule
`default_nettype wire
